FILE: hw/rtl/tips_pkg.sv
// ----------------------------------------------------------------------------
// tips_pkg
// Shared widths, register indexes, reset values and status types for the
// touch and IR presence switch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tips_pkg;

  localparam int KEY_W   = 16;
  localparam int MODE_W  = 3;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int EMPTY_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_HIT_THRESHOLD  = 2'd1,
    REG_EMIT_OFF_AFTER = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST  = 8'd20;
  localparam logic [CFG_W-1:0] HIT_THRESHOLD_RST  = 8'd2;
  localparam logic [CFG_W-1:0] EMIT_OFF_AFTER_RST = 8'd10;

  localparam logic [KEY_W-1:0] KEY_A0   = 16'd1;
  localparam logic [KEY_W-1:0] KEY_A1   = 16'd4;
  localparam logic [KEY_W-1:0] KEY_B0   = 16'd2;
  localparam logic [KEY_W-1:0] KEY_B1   = 16'd8;
  localparam logic [KEY_W-1:0] KEY_BOTH = 16'd3;

  typedef struct packed {
    logic              release_toggle;
    logic [MODE_W-1:0] mode_a;
    logic [MODE_W-1:0] mode_b;
    logic              both;
  } key_status_t;

  typedef struct packed {
    logic entry_toggle;
    logic presence;
    logic emit;
  } ir_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tips_if.sv
// ----------------------------------------------------------------------------
// tips interfaces
// Request, result and configuration channels of the touch and IR presence
// switch, each a valid/ready channel with source and sink views.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tips_req_if;
  logic                        valid;
  logic                        ready;
  logic [tips_pkg::KEY_W-1:0]  key_bits;
  logic                        ir_seen;

  modport source (output valid, output key_bits, output ir_seen, input ready);
  modport sink   (input valid, input key_bits, input ir_seen, output ready);
endinterface

interface tips_res_if;
  logic                        valid;
  logic                        ready;
  logic                        power_on;
  logic                        emit_enable;
  logic [tips_pkg::MODE_W-1:0] mode_a;
  logic [tips_pkg::MODE_W-1:0] mode_b;
  logic                        both_pressed;
  logic                        presence;

  modport source (output valid, output power_on, output emit_enable, output mode_a,
                  output mode_b, output both_pressed, output presence, input ready);
  modport sink   (input valid, input power_on, input emit_enable, input mode_a,
                  input mode_b, input both_pressed, input presence, output ready);
endinterface

interface tips_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tips_pkg::CFG_IDX_W-1:0] index;
  logic [tips_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tips_keys.sv
// ----------------------------------------------------------------------------
// tips_keys
// Touch key edge handling: mode stepping, both-pressed flag and the
// release toggle of power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tips_keys #(
  parameter int MODE_COUNT = 5
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          step,
  input  wire [tips_pkg::KEY_W-1:0]    keys,
  input  wire                          power,
  output tips_pkg::key_status_t        status
);
  import tips_pkg::*;

  localparam logic [MODE_W-1:0] MODE_MAX = MODE_W'(MODE_COUNT);
  localparam logic [MODE_W-1:0] MODE_ONE = MODE_W'(1);

  logic [KEY_W-1:0]  last_keys, last_keys_next;
  logic              key_locked, key_locked_next;
  logic              toggle_pending, toggle_pending_next;
  logic [MODE_W-1:0] mode_a, mode_a_next;
  logic [MODE_W-1:0] mode_b, mode_b_next;
  logic              both_flag, both_flag_next;
  logic [MODE_W-1:0] mode_a_inc, mode_b_inc;

  always_comb begin
    mode_a_inc = mode_a + MODE_ONE;
    if (mode_a_inc > MODE_MAX) mode_a_inc = MODE_ONE;
    mode_b_inc = mode_b + MODE_ONE;
    if (mode_b_inc > MODE_MAX) mode_b_inc = MODE_ONE;
  end

  always_comb begin
    last_keys_next      = last_keys;
    key_locked_next     = key_locked;
    toggle_pending_next = toggle_pending;
    mode_a_next         = mode_a;
    mode_b_next         = mode_b;
    both_flag_next      = both_flag;
    status.release_toggle = 1'b0;
    if (keys != '0) begin
      key_locked_next = 1'b1;
      if (keys != last_keys) begin
        if (key_locked) begin
          toggle_pending_next = 1'b1;
        end else begin
          last_keys_next = keys;
          if (keys == KEY_A0 || keys == KEY_A1) begin
            if (power) mode_a_next = mode_a_inc;
          end else if (keys == KEY_B0 || keys == KEY_B1) begin
            if (power) mode_b_next = mode_b_inc;
          end else if (keys == KEY_BOTH) begin
            both_flag_next = 1'b1;
          end
        end
      end
    end else begin
      last_keys_next        = '0;
      key_locked_next       = 1'b0;
      toggle_pending_next   = 1'b0;
      status.release_toggle = toggle_pending;
    end
    status.mode_a = mode_a_next;
    status.mode_b = mode_b_next;
    status.both   = both_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_keys      <= '0;
      key_locked     <= 1'b0;
      toggle_pending <= 1'b0;
      mode_a         <= MODE_ONE;
      mode_b         <= MODE_ONE;
      both_flag      <= 1'b0;
    end else if (step) begin
      last_keys      <= last_keys_next;
      key_locked     <= key_locked_next;
      toggle_pending <= toggle_pending_next;
      mode_a         <= mode_a_next;
      mode_b         <= mode_b_next;
      both_flag      <= both_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tips_ir.sv
// ----------------------------------------------------------------------------
// tips_ir
// IR presence detector: hit counting per window, presence with two empty
// windows to clear, and emitter gating late in the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tips_ir (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        step,
  input  wire                        seen,
  input  wire [tips_pkg::CFG_W-1:0]  window_length,
  input  wire [tips_pkg::CFG_W-1:0]  hit_threshold,
  input  wire [tips_pkg::CFG_W-1:0]  emit_off_after,
  output tips_pkg::ir_status_t       status
);
  import tips_pkg::*;

  logic [CFG_W-1:0]   window_pos, window_pos_next;
  logic [CFG_W-1:0]   hit_count, hit_count_next;
  logic [EMPTY_W-1:0] empty_windows, empty_windows_next;
  logic               present, present_next;
  logic               emit;
  logic [CFG_W-1:0]   hit_inc, pos_inc;
  logic [EMPTY_W-1:0] empty_inc;

  always_comb begin
    hit_inc   = hit_count + CFG_W'(seen);
    pos_inc   = window_pos + CFG_W'(1);
    empty_inc = empty_windows + EMPTY_W'(1);

    window_pos_next    = pos_inc;
    hit_count_next     = hit_inc;
    empty_windows_next = empty_windows;
    present_next       = present;
    emit               = !((window_pos > emit_off_after) && present);
    status.entry_toggle = 1'b0;

    if (pos_inc >= window_length) begin
      if (hit_inc > hit_threshold) begin
        if (!present) begin
          present_next        = 1'b1;
          status.entry_toggle = 1'b1;
        end
        empty_windows_next = '0;
      end else if (empty_inc > EMPTY_W'(1)) begin
        empty_windows_next = EMPTY_W'(1);
        present_next       = 1'b0;
      end else begin
        empty_windows_next = empty_inc;
      end
      emit            = 1'b1;
      window_pos_next = '0;
      hit_count_next  = '0;
    end

    status.presence = present_next;
    status.emit     = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_pos    <= '0;
      hit_count     <= '0;
      empty_windows <= '0;
      present       <= 1'b0;
    end else if (step) begin
      window_pos    <= window_pos_next;
      hit_count     <= hit_count_next;
      empty_windows <= empty_windows_next;
      present       <= present_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/touch_and_ir_presence_switch.sv
// ----------------------------------------------------------------------------
// touch_and_ir_presence_switch
// Touch key and IR presence power switch, one service step per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless the result side stalls and
// returns one result per request, in order, in the cycle after acceptance.
// All state is updated in a single combinational pass at the accepting edge
// and the flags are captured into the result register; a request is taken
// whenever that register is empty or being drained in the same cycle.
// Configuration writes are always accepted, effective from the next request.
`timescale 1ns / 1ps
`default_nettype none

module touch_and_ir_presence_switch #(
  parameter int MODE_COUNT = 5
) (
  input  wire         clk,
  input  wire         rst,
  tips_req_if.sink    req,
  tips_res_if.source  res,
  tips_cfg_if.sink    cfg
);
  import tips_pkg::*;

  logic [CFG_W-1:0] window_length;
  logic [CFG_W-1:0] hit_threshold;
  logic [CFG_W-1:0] emit_off_after;
  logic             power;
  logic             power_next;
  logic             step;
  key_status_t      key_status;
  ir_status_t       ir_status;

  assign cfg.ready = 1'b1;
  assign req.ready = !res.valid || res.ready;
  assign step      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_LENGTH_RST;
      hit_threshold  <= HIT_THRESHOLD_RST;
      emit_off_after <= EMIT_OFF_AFTER_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_WINDOW_LENGTH:  window_length  <= cfg.data;
        REG_HIT_THRESHOLD:  hit_threshold  <= cfg.data;
        REG_EMIT_OFF_AFTER: emit_off_after <= cfg.data;
        default: ;
      endcase
    end
  end

  tips_keys #(
    .MODE_COUNT(MODE_COUNT)
  ) u_keys (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .keys   (req.key_bits),
    .power  (power),
    .status (key_status)
  );

  tips_ir u_ir (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .seen           (req.ir_seen),
    .window_length  (window_length),
    .hit_threshold  (hit_threshold),
    .emit_off_after (emit_off_after),
    .status         (ir_status)
  );

  // release toggle first, then presence entry toggle
  assign power_next = power ^ key_status.release_toggle ^ ir_status.entry_toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      power     <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (step) begin
        power     <= power_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.power_on     <= power_next;
      res.emit_enable  <= ir_status.emit;
      res.mode_a       <= key_status.mode_a;
      res.mode_b       <= key_status.mode_b;
      res.both_pressed <= key_status.both;
      res.presence     <= ir_status.presence;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_touch_and_ir_presence_switch.sv
// ----------------------------------------------------------------------------
// tb_touch_and_ir_presence_switch
// Self-checking bench for the touch and IR presence power switch. A driver
// feeds service-step requests from a queue in random bursts, the result side
// stalls on its own pattern, and a monitor checks every result against a
// cycle-free model of the key, mode, power and presence logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_touch_and_ir_presence_switch;
  import tips_pkg::*;

  localparam int SEL_COUNT      = 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 160;

  typedef struct packed {
    logic [KEY_W-1:0] key_bits;
    logic             ir_seen;
  } step_t;

  typedef struct packed {
    logic              power_on;
    logic              emit_enable;
    logic [MODE_W-1:0] mode_a;
    logic [MODE_W-1:0] mode_b;
    logic              both_pressed;
    logic              presence;
  } flags_t;

  typedef struct packed {
    logic [KEY_W-1:0]   held_keys;
    logic               locked;
    logic               toggle_armed;
    logic               power;
    logic [MODE_W-1:0]  sel_a;
    logic [MODE_W-1:0]  sel_b;
    logic               both;
    logic [CFG_W-1:0]   win_pos;
    logic [CFG_W-1:0]   hits;
    logic [EMPTY_W-1:0] empties;
    logic               present;
    logic               emit;
  } switch_state_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_style_t;

  logic clk;
  logic rst;

  tips_req_if req_ch ();
  tips_res_if res_ch ();
  tips_cfg_if cfg_ch ();

  touch_and_ir_presence_switch #(
    .MODE_COUNT (SEL_COUNT)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  step_t         step_queue[$];
  flags_t        flags_due[$];
  switch_state_t sw;
  logic [CFG_W-1:0] win_len;
  logic [CFG_W-1:0] hit_thr;
  logic [CFG_W-1:0] emit_off;

  int unsigned err_count;
  int unsigned results_seen;
  int unsigned ir_density;
  logic        req_fired;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [MODE_W-1:0] next_sel(input logic [MODE_W-1:0] m);
    logic [3:0] n;
    n = ({1'b0, m} + 4'd1) & 4'd7;
    if (n > SEL_COUNT) n = 4'd1;
    return n[MODE_W-1:0];
  endfunction

  task automatic advance_switch(input step_t s, output flags_t f);
    // key edges
    if (s.key_bits != '0) begin
      if (s.key_bits != sw.held_keys && sw.locked) begin
        sw.toggle_armed = 1'b1;
      end else begin
        if (s.key_bits != sw.held_keys) begin
          sw.held_keys = s.key_bits;
          if (s.key_bits == KEY_A0 || s.key_bits == KEY_A1) begin
            if (sw.power) sw.sel_a = next_sel(sw.sel_a);
          end else if (s.key_bits == KEY_B0 || s.key_bits == KEY_B1) begin
            if (sw.power) sw.sel_b = next_sel(sw.sel_b);
          end else if (s.key_bits == KEY_BOTH) begin
            sw.both = 1'b1;
          end
        end
        sw.locked = 1'b1;
      end
    end else begin
      sw.held_keys = '0;
      sw.locked    = 1'b0;
      if (sw.toggle_armed) sw.power = ~sw.power;
      sw.toggle_armed = 1'b0;
    end
    // ir window
    if (s.ir_seen) sw.hits = sw.hits + 8'd1;
    sw.emit    = !(sw.win_pos > emit_off && sw.present);
    sw.win_pos = sw.win_pos + 8'd1;
    if (sw.win_pos >= win_len) begin
      if (sw.hits > hit_thr) begin
        if (!sw.present) begin
          sw.present = 1'b1;
          sw.power   = ~sw.power;
        end
        sw.empties = '0;
      end else begin
        sw.empties = sw.empties + 2'd1;
        if (sw.empties > 2'd1) begin
          sw.empties = 2'd1;
          sw.present = 1'b0;
        end
      end
      sw.emit    = 1'b1;
      sw.win_pos = '0;
      sw.hits    = '0;
    end
    f.power_on     = sw.power;
    f.emit_enable  = sw.emit;
    f.mode_a       = sw.sel_a;
    f.mode_b       = sw.sel_b;
    f.both_pressed = sw.both;
    f.presence     = sw.present;
  endtask

  task automatic check_flag(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // request driver
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fired) begin
      // offer stays up until taken
    end else begin
      if (req_fired) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (step_queue.size() > 0) begin
        req_ch.valid    <= 1'b1;
        req_ch.key_bits <= step_queue[0].key_bits;
        req_ch.ir_seen  <= step_queue[0].ir_seen;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  ready_style_t ready_style;
  int unsigned  style_left;
  int unsigned  hold_left;
  logic         hold_done;
  logic [7:0]   stall_bits;

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_done    = 1'b0;
      hold_left    = 0;
      style_left   = 0;
    end else begin
      if (!hold_done && results_seen >= 300 && step_queue.size() > 50) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          case ($urandom_range(0, 2))
            0:       ready_style = READY_ALWAYS;
            1:       ready_style = READY_RANDOM;
            default: ready_style = READY_PATTERN;
          endcase
          style_left = $urandom_range(20, 80);
          stall_bits = 8'($urandom_range(0, 255)) | 8'h01;
        end
        style_left--;
        case (ready_style)
          READY_ALWAYS: res_ch.ready <= 1'b1;
          READY_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            res_ch.ready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[7:1]};
          end
        endcase
      end
    end
  end

  // monitor and predictor
  step_t  taken;
  flags_t want;
  flags_t got;

  always @(posedge clk) begin
    req_fired = !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (flags_due.size() == 0) begin
          $error("result with no request outstanding");
          err_count++;
        end else begin
          want = flags_due.pop_front();
          check_flag("power_on", want.power_on, res_ch.power_on);
          check_flag("emit_enable", want.emit_enable, res_ch.emit_enable);
          check_flag("mode_a", want.mode_a, res_ch.mode_a);
          check_flag("mode_b", want.mode_b, res_ch.mode_b);
          check_flag("both_pressed", want.both_pressed, res_ch.both_pressed);
          check_flag("presence", want.presence, res_ch.presence);
        end
      end
      if (req_fired) begin
        taken = step_queue.pop_front();
        advance_switch(taken, got);
        flags_due.push_back(got);
      end
    end
  end

  // watchdog
  int unsigned idle_cycles;

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL touch_and_ir_presence_switch");
    $finish;
  end

  task automatic queue_step(input logic [KEY_W-1:0] keys, input logic ir);
    step_t s;
    s.key_bits = keys;
    s.ir_seen  = ir;
    step_queue.push_back(s);
  endtask

  function automatic logic pick_ir();
    return $urandom_range(0, 99) < ir_density;
  endfunction

  function automatic logic [KEY_W-1:0] pick_code();
    case ($urandom_range(0, 4))
      0:       return KEY_A0;
      1:       return KEY_A1;
      2:       return KEY_B0;
      3:       return KEY_B1;
      default: return KEY_BOTH;
    endcase
  endfunction

  task automatic queue_random_steps(input int n);
    int base;
    int chunk;
    int kind;
    logic [KEY_W-1:0] code;
    logic [KEY_W-1:0] other;
    base  = step_queue.size();
    chunk = 0;
    while (step_queue.size() - base < n) begin
      if (chunk <= 0) begin
        case ($urandom_range(0, 4))
          0:       ir_density = 0;
          1:       ir_density = 10;
          2:       ir_density = 40;
          3:       ir_density = 80;
          default: ir_density = 100;
        endcase
        chunk = $urandom_range(10, 60);
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        code = pick_code();
        repeat ($urandom_range(1, 4)) queue_step(code, pick_ir());
        repeat ($urandom_range(1, 3)) queue_step('0, pick_ir());
      end else if (kind < 65) begin
        code  = pick_code();
        other = ($urandom_range(0, 1) == 0) ? pick_code() : KEY_W'($urandom_range(1, 65535));
        repeat ($urandom_range(1, 3)) queue_step(code, pick_ir());
        repeat ($urandom_range(1, 3)) queue_step(other, pick_ir());
        repeat ($urandom_range(1, 3)) queue_step('0, pick_ir());
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 3)) queue_step(KEY_W'($urandom_range(0, 65535)), pick_ir());
        queue_step('0, pick_ir());
      end else if (kind < 85) begin
        code = KEY_W'($urandom_range(1, 65535));
        while (code == KEY_A0 || code == KEY_A1 || code == KEY_B0 || code == KEY_B1 ||
               code == KEY_BOTH)
          code = KEY_W'($urandom_range(1, 65535));
        repeat ($urandom_range(1, 3)) queue_step(code, pick_ir());
        queue_step('0, pick_ir());
      end else begin
        repeat ($urandom_range(1, 6)) queue_step('0, pick_ir());
      end
      chunk = chunk - 3;
    end
  endtask

  task automatic settle();
    while (step_queue.size() != 0 || flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH:  win_len  = val;
      REG_HIT_THRESHOLD:  hit_thr  = val;
      REG_EMIT_OFF_AFTER: emit_off = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_window(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] thr,
                            input logic [CFG_W-1:0] off);
    settle();
    write_reg(REG_WINDOW_LENGTH, len);
    write_reg(REG_HIT_THRESHOLD, thr);
    write_reg(REG_EMIT_OFF_AFTER, off);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] thr,
                           input logic [CFG_W-1:0] off, input int n);
    set_window(len, thr, off);
    queue_random_steps(n);
  endtask

  int unsigned r_len;

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.key_bits = '0;
    req_ch.ir_seen  = 1'b0;
    res_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_WINDOW_LENGTH;
    cfg_ch.data     = '0;
    err_count       = 0;
    results_seen    = 0;
    ir_density      = 0;
    req_fired       = 1'b0;
    burst_left      = 0;
    gap_left        = 0;
    win_len         = WINDOW_LENGTH_RST;
    hit_thr         = HIT_THRESHOLD_RST;
    emit_off        = EMIT_OFF_AFTER_RST;
    sw              = '0;
    sw.sel_a        = 3'd1;
    sw.sel_b        = 3'd1;
    sw.emit         = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset window settings: modes ignored while off, sticky both flag,
    // unknown code, change while held, then mode stepping and presence entry
    queue_step('0, 1'b0);
    queue_step(KEY_A0, 1'b0);
    queue_step('0, 1'b0);
    queue_step(KEY_B1, 1'b0);
    queue_step('0, 1'b1);
    queue_step(KEY_BOTH, 1'b1);
    queue_step('0, 1'b1);
    queue_step(16'h0005, 1'b1);
    queue_step(16'h8000, 1'b0);
    queue_step('0, 1'b0);
    queue_step(KEY_A0, 1'b1);
    queue_step(KEY_A0, 1'b0);
    queue_step('0, 1'b0);
    queue_step(KEY_A1, 1'b0);
    queue_step('0, 1'b0);
    queue_step(KEY_B0, 1'b0);
    queue_step('0, 1'b0);
    queue_step(KEY_B1, 1'b0);
    queue_step('0, 1'b0);
    queue_step(16'hFFFF, 1'b0);
    queue_step('0, 1'b0);
    queue_random_steps(120);

    // one-sample window: release toggle and presence entry on the same step
    set_window(8'd1, 8'd0, 8'd0);
    queue_step(KEY_A0, 1'b0);
    queue_step(KEY_B0, 1'b0);
    queue_step('0, 1'b1);
    queue_random_steps(120);

    run_phase(8'd0, 8'd0, 8'd0, 120);
    settle();
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    run_phase(8'd2, 8'd1, 8'd0, 150);
    run_phase(8'd255, 8'd255, 8'd255, 150);
    run_phase(8'd255, 8'd0, 8'd254, 150);
    run_phase(8'd5, 8'd4, 8'd255, 120);
    run_phase(WINDOW_LENGTH_RST, HIT_THRESHOLD_RST, EMIT_OFF_AFTER_RST, 150);
    repeat (3) begin
      r_len = $urandom_range(2, 40);
      run_phase(8'(r_len), 8'($urandom_range(0, r_len)), 8'($urandom_range(0, r_len)), 150);
    end

    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS touch_and_ir_presence_switch");
    end else begin
      $display("FAIL touch_and_ir_presence_switch");
    end
    $finish;
  end

endmodule
